>>> src/hsc_pkg.sv
// Shared types, constants and arithmetic helpers for the hyperspherical-to-Cartesian row block.
// Used by every module in this folder; depends on nothing else.
package hsc_pkg;

   localparam int ANGLES_PER_ROW = 3;
   localparam int ANGLE_BITS     = 16;
   localparam int VALUE_BITS     = 16;

   localparam int FRAC_BITS      = VALUE_BITS - 1;
   localparam int ROUND_SHIFT    = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
   localparam int LEFT_SHIFT     = (FRAC_BITS > 30) ? FRAC_BITS - 30 : 0;
   localparam int STEP_COUNT     = 5;
   localparam int SINE_LATENCY   = 3 * STEP_COUNT + 3;
   localparam int REQ_DATA_BITS  = ((ANGLES_PER_ROW * ANGLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = (((ANGLES_PER_ROW + 1) * VALUE_BITS + 7) / 8) * 8;

   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   localparam logic [6:0] SERIES_DIV [STEP_COUNT] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [31:0] SERIES_RECIP [STEP_COUNT] = '{
      32'((64'd1 << 32) / 64'd110),
      32'((64'd1 << 32) / 64'd72),
      32'((64'd1 << 32) / 64'd42),
      32'((64'd1 << 32) / 64'd20),
      32'((64'd1 << 32) / 64'd6)
   };

   typedef struct packed {
      logic        neg;
      logic [30:0] mag;
   } sq30_type;

   // round half away from zero on the magnitude
   function automatic sq30_type mul_q30(input sq30_type a, input sq30_type b);
      logic [61:0] full;
      sq30_type    res;
      full    = 62'(a.mag) * 62'(b.mag) + 62'(ONE_Q30 >> 1);
      res.mag = full[60:30];
      res.neg = (a.neg ^ b.neg) && (res.mag != '0);
      return res;
   endfunction

   function automatic logic [VALUE_BITS-1:0] to_output(input sq30_type v);
      logic [63:0] m;
      logic [63:0] lim;
      m   = 64'(v.mag);
      lim = 64'd1 << FRAC_BITS;
      m   = (m + ((64'd1 << ROUND_SHIFT) >> 1)) >> ROUND_SHIFT;
      m   = m << LEFT_SHIFT;
      if (v.neg) begin
         if (m > lim) m = lim;
         return VALUE_BITS'(64'd0 - m);
      end
      if (m > lim - 64'd1) m = lim - 64'd1;
      return VALUE_BITS'(m);
   endfunction

endpackage

>>> src/hyperspherical_to_cartesian_row.sv
// Hyperspherical-to-Cartesian row converter, top level. Depends on hsc_pkg, hsc_lane, hsc_merge.
// Each accepted row passes the sine pipeline, the product chain and the output register to its result.
// Throughput: one row per cycle; the sine pipeline (five series steps of three stages) and the
// one-lane-per-stage product chain advance together, stalled only by the output register.
// Reset: synchronous, active high; empties the pipeline, no result valid afterwards.
module hyperspherical_to_cartesian_row (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hsc_pkg::REQ_DATA_BITS-1:0] req_tdata,  // angle_0, angle_1, angle_2
   input  logic                              req_tlast,  // row_last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hsc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // b_0, b_1, b_2, b_3
   output logic                              rsp_tlast   // row_last_out
);
   import hsc_pkg::*;

   localparam int PIPE_LATENCY = SINE_LATENCY + ANGLES_PER_ROW;

   logic                                           enable;
   logic [PIPE_LATENCY-1:0]                        valid_ff, valid_in;
   logic [PIPE_LATENCY-1:0]                        last_ff;
   sq30_type [ANGLES_PER_ROW-1:0]                  sin_value, cos_value;
   logic [ANGLES_PER_ROW:0][VALUE_BITS-1:0]        row_value;
   logic                                           rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0]                       rsp_data_ff;
   logic                                           rsp_last_ff;

   // advance whenever the output register is free or being drained
   assign enable     = !rsp_valid_ff || rsp_tready;
   assign req_tready = enable;
   assign valid_in   = {valid_ff[PIPE_LATENCY-2:0], req_tvalid};

   for (genvar j = 0; j < ANGLES_PER_ROW; j++) begin : g_lane
      hsc_lane u_lane (
         .clock     (clock),
         .enable    (enable),
         .angle     (req_tdata[j*ANGLE_BITS +: ANGLE_BITS]),
         .sin_value (sin_value[j]),
         .cos_value (cos_value[j])
      );
   end

   hsc_merge u_merge (
      .clock     (clock),
      .enable    (enable),
      .sin_value (sin_value),
      .cos_value (cos_value),
      .row_value (row_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[PIPE_LATENCY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         last_ff     <= {last_ff[PIPE_LATENCY-2:0], req_tlast};
         rsp_last_ff <= last_ff[PIPE_LATENCY-1];
         rsp_data_ff <= RSP_DATA_BITS'(row_value);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_reset_empties : assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_ready_follows_output : assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output register state");

   a_stall_holds_result : assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while pipeline stalled");

endmodule

>>> src/hsc_sine.sv
// Pipelined fixed-point sine of a turn-fraction angle, result in signed Q30.
// Depends on hsc_pkg.
module hsc_sine (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [hsc_pkg::ANGLE_BITS-1:0] angle,
   output hsc_pkg::sq30_type              result
);
   import hsc_pkg::*;

   logic [1:0]  quad;
   logic [29:0] u_raw;
   logic [30:0] u;
   logic [30:0] r1_ff;
   logic [1:0]  quad1_ff;
   logic [30:0] r2_r_ff;
   logic [31:0] r2_ff;
   logic [1:0]  quad2_ff;

   logic [30:0] h_src    [STEP_COUNT+1];
   logic [30:0] r_src    [STEP_COUNT+1];
   logic [31:0] r2_src   [STEP_COUNT+1];
   logic [1:0]  quad_src [STEP_COUNT+1];

   logic [61:0] s_full;
   logic [30:0] s_in;
   sq30_type    result_ff;

   always_comb begin
      quad  = angle[ANGLE_BITS-1 -: 2];
      u_raw = 30'(angle[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
      u     = quad[0] ? ONE_Q30 - {1'b0, u_raw} : {1'b0, u_raw};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         r1_ff    <= 31'((62'(u) * 62'(PI_HALF_Q30)) >> 30);
         quad1_ff <= quad;
         r2_ff    <= 32'((64'(r1_ff) * 64'(r1_ff)) >> 30);
         r2_r_ff  <= r1_ff;
         quad2_ff <= quad1_ff;
      end
   end

   assign h_src[0]    = ONE_Q30;
   assign r_src[0]    = r2_r_ff;
   assign r2_src[0]   = r2_ff;
   assign quad_src[0] = quad2_ff;

   for (genvar i = 0; i < STEP_COUNT; i++) begin : g_step
      logic [31:0] xa_ff, xb_ff, qe_ff;
      logic [30:0] ra_ff, rb_ff, rc_ff, h_ff;
      logic [31:0] r2a_ff, r2b_ff, r2c_ff;
      logic [1:0]  qa_ff, qb_ff, qc_ff;
      logic [63:0] est_full;
      logic [39:0] rem;
      logic [31:0] quot_in;

      always_comb begin
         est_full = 64'(xa_ff) * 64'(SERIES_RECIP[i]);
         rem      = 40'(xb_ff) - 40'(qe_ff) * 40'(SERIES_DIV[i]);
         quot_in  = qe_ff + 32'(rem >= 40'(SERIES_DIV[i]));
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            xa_ff  <= 32'((64'(r2_src[i]) * 64'(h_src[i])) >> 30);
            ra_ff  <= r_src[i];
            r2a_ff <= r2_src[i];
            qa_ff  <= quad_src[i];
            qe_ff  <= est_full[63:32];
            xb_ff  <= xa_ff;
            rb_ff  <= ra_ff;
            r2b_ff <= r2a_ff;
            qb_ff  <= qa_ff;
            h_ff   <= ONE_Q30 - quot_in[30:0];
            rc_ff  <= rb_ff;
            r2c_ff <= r2b_ff;
            qc_ff  <= qb_ff;
         end
      end

      assign h_src[i+1]    = h_ff;
      assign r_src[i+1]    = rc_ff;
      assign r2_src[i+1]   = r2c_ff;
      assign quad_src[i+1] = qc_ff;
   end

   always_comb begin
      s_full = 62'(r_src[STEP_COUNT]) * 62'(h_src[STEP_COUNT]);
      s_in   = (s_full[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : s_full[60:30];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff.mag <= s_in;
         result_ff.neg <= quad_src[STEP_COUNT][1] && (s_in != '0);
      end
   end

   assign result = result_ff;

endmodule

>>> src/hsc_lane.sv
// One angle lane: sine and cosine of the lane's angle, both in signed Q30.
// Depends on hsc_pkg and hsc_sine.
module hsc_lane (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [hsc_pkg::ANGLE_BITS-1:0] angle,
   output hsc_pkg::sq30_type              sin_value,
   output hsc_pkg::sq30_type              cos_value
);
   import hsc_pkg::*;

   logic [ANGLE_BITS-1:0] cos_angle;

   assign cos_angle = angle + QUARTER_TURN;

   hsc_sine u_sin (
      .clock  (clock),
      .enable (enable),
      .angle  (angle),
      .result (sin_value)
   );

   hsc_sine u_cos (
      .clock  (clock),
      .enable (enable),
      .angle  (cos_angle),
      .result (cos_value)
   );

endmodule

>>> src/hsc_merge.sv
// Merge: running sine product and cosine-times-product per lane, one lane per stage; Q1.x output.
// Depends on hsc_pkg.
module hsc_merge (
   input  logic                                                      clock,
   input  logic                                                      enable,
   input  hsc_pkg::sq30_type [hsc_pkg::ANGLES_PER_ROW-1:0]           sin_value,
   input  hsc_pkg::sq30_type [hsc_pkg::ANGLES_PER_ROW-1:0]           cos_value,
   output logic [hsc_pkg::ANGLES_PER_ROW:0][hsc_pkg::VALUE_BITS-1:0] row_value
);
   import hsc_pkg::*;

   sq30_type [ANGLES_PER_ROW-1:0] sin_src  [ANGLES_PER_ROW+1];
   sq30_type [ANGLES_PER_ROW-1:0] cos_src  [ANGLES_PER_ROW+1];
   sq30_type [ANGLES_PER_ROW-1:0] b_src    [ANGLES_PER_ROW+1];
   sq30_type                      prod_src [ANGLES_PER_ROW+1];

   assign sin_src[0]  = sin_value;
   assign cos_src[0]  = cos_value;
   assign b_src[0]    = '0;
   assign prod_src[0] = '{neg: 1'b0, mag: ONE_Q30};

   for (genvar k = 0; k < ANGLES_PER_ROW; k++) begin : g_stage
      sq30_type [ANGLES_PER_ROW-1:0] sin_ff, cos_ff, b_ff, b_in;
      sq30_type                      prod_ff;

      always_comb begin
         b_in    = b_src[k];
         b_in[k] = mul_q30(cos_src[k][k], prod_src[k]);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            sin_ff  <= sin_src[k];
            cos_ff  <= cos_src[k];
            b_ff    <= b_in;
            prod_ff <= mul_q30(prod_src[k], sin_src[k][k]);
         end
      end

      assign sin_src[k+1]  = sin_ff;
      assign cos_src[k+1]  = cos_ff;
      assign b_src[k+1]    = b_ff;
      assign prod_src[k+1] = prod_ff;
   end

   always_comb begin
      for (int j = 0; j < ANGLES_PER_ROW; j++) begin
         row_value[j] = to_output(b_src[ANGLES_PER_ROW][j]);
      end
      row_value[ANGLES_PER_ROW] = to_output(prod_src[ANGLES_PER_ROW]);
   end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for hyperspherical_to_cartesian_row: random and directed angle rows,
// each predicted in fixed point and compared with the block's output rows.
// Depends on hsc_pkg for widths and on the RTL of the block.
`timescale 1ns / 100ps

class row_scoreboard;
   typedef struct {
      logic [15:0] b [4];
      logic        last;
   } row_type;

   row_type pending [$];
   int      mismatches;
   int      rows_checked;

   static function logic [31:0] sine_mag(input logic [15:0] a, output logic neg);
      logic [1:0]  q;
      logic [63:0] u, r, r2, h, s;
      logic [63:0] divs [5];
      divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      q = a[15:14];
      u = 64'(a[13:0]) << 16;
      if (q == 2'd1 || q == 2'd3) u = (64'd1 << 30) - u;
      r = (u * 64'd1686629713) >> 30;
      r2 = (r * r) >> 30;
      h = 64'd1 << 30;
      for (int i = 0; i < 5; i++) h = (64'd1 << 30) - (((r2 * h) >> 30) / divs[i]);
      s = (r * h) >> 30;
      if (s > (64'd1 << 30)) s = 64'd1 << 30;
      neg = q[1] && (s != 0);
      return s[31:0];
   endfunction

   static function void product(input logic an, input logic [31:0] am, input logic bn,
                                input logic [31:0] bm, output logic rn, output logic [31:0] rm);
      logic [63:0] p;
      p = 64'(am) * 64'(bm) + (64'd1 << 29);
      rm = 32'(p >> 30);
      rn = (an != bn) && (rm != 0);
   endfunction

   static function logic [15:0] quantise(input logic n, input logic [31:0] mag);
      logic [63:0] m;
      m = (64'(mag) + (64'd1 << 14)) >> 15;
      if (n) begin
         if (m > 64'd32768) m = 64'd32768;
         return 16'(64'd0 - m);
      end
      if (m > 64'd32767) m = 64'd32767;
      return 16'(m);
   endfunction

   function void note_row(input logic [47:0] angles, input logic last);
      row_type     e;
      logic        pn, cn, sn, tn;
      logic [31:0] pm, cm, sm, tm;
      logic [15:0] a;
      pn = 0;
      pm = 32'd1 << 30;
      for (int j = 0; j < 3; j++) begin
         a = angles[16*j +: 16];
         cm = sine_mag(a + 16'h4000, cn);
         sm = sine_mag(a, sn);
         product(cn, cm, pn, pm, tn, tm);
         e.b[j] = quantise(tn, tm);
         product(pn, pm, sn, sm, pn, pm);
      end
      e.b[3] = quantise(pn, pm);
      e.last = last;
      pending.push_back(e);
   endfunction

   function void check_row(input logic [63:0] data, input logic last);
      row_type e;
      bit      bad;
      rows_checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected row %h last %b", data, last);
         return;
      end
      e = pending.pop_front();
      bad = (last !== e.last);
      for (int j = 0; j < 4; j++) if (data[16*j +: 16] !== e.b[j]) bad = 1;
      if (bad) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %h %h %h %h last %b, got %h last %b",
                     e.b[3], e.b[2], e.b[1], e.b[0], e.last, data, last);
      end
   endfunction
endclass

module testbench;
   import hsc_pkg::*;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_tvalid = 0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     req_tlast = 0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;

   row_scoreboard board = new();
   int  send_idle = 0;
   int  recv_stall = 0;
   int  hold_off = 0;
   int  cycles = 0;
   bit  stim_done = 0;

   hyperspherical_to_cartesian_row uut (.*);

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver side, with an optional long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_row(rsp_tdata, rsp_tlast);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h4000 * 16'($urandom_range(3));
         3: return 16'h4000 * 16'($urandom_range(3)) + 16'($urandom_range(2)) - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_row(input logic [47:0] angles, input logic last);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= angles;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_row(angles, last);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_row({pick_angle(), pick_angle(), pick_angle()}, 1'($urandom));
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [15:0] corners [8];
      corners = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h2000, 16'h3fff,
                  16'h7fff};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 8; i++)
         send_row({corners[(i + 2) % 8], corners[(i + 1) % 8], corners[i]}, 1'(i));
      send_row(48'h0, 0);
      send_row(48'hffff_ffff_ffff, 1);
      send_row({16'h4000, 16'h4000, 16'h4000}, 1);
      send_row({16'h0000, 16'hc000, 16'h8000}, 0);
      send_idle = 0;  recv_stall = 0;  send_random(300);
      drain();
      hold_off = 200;
      send_random(60);
      drain();
      send_idle = 72; recv_stall = 0;  send_random(300);
      send_idle = 0;  recv_stall = 72; send_random(300);
      send_idle = 20; recv_stall = 20; send_random(320);
      drain();
      recv_stall = 0;
      repeat (40) @(posedge clock);
      stim_done = 1;
      $display("rows checked: %0d, covering quadrant edges, all-ones and random angles",
               board.rows_checked);
      $display("phases: free flow, sender gaps, receiver stalls, mixed, long output hold-off");
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

>>> filelist.f
src/hsc_pkg.sv
src/hsc_sine.sv
src/hsc_lane.sv
src/hsc_merge.sv
src/hyperspherical_to_cartesian_row.sv
tb/testbench.sv
